[design/sjjc_pkg.sv]
// types, constants and helpers shared by the servo joint jog controller
`timescale 1ns / 1ps

package sjjc_pkg;

    localparam int POS_W       = 7;
    localparam int PULSE_W     = 22;
    localparam int JOINT_OUT_W = 3;
    localparam int CODE_W      = 4;
    localparam int MASK_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam int PULSE_STEP_NS = 20000;
    localparam int PULSE_BASE_NS = 1000000;

    localparam logic [POS_W-1:0]  POS_RESET       = 7'd50;
    localparam logic [POS_W-1:0]  POS_RESET_JOINT1 = 7'd28;
    localparam logic [MASK_W-1:0] INVERT_RESET    = 5'd18;
    localparam logic [POS_W-1:0]  POS_MIN_RESET   = 7'd0;
    localparam logic [POS_W-1:0]  POS_MAX_RESET   = 7'd100;

    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MAX = 2'd2;

    typedef enum logic [1:0] {
        DIR_STILL = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_BACK  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [CODE_W-1:0] joint_code;
        logic [1:0]        jog_direction;
    } tick_item_t;

    typedef struct packed {
        logic [JOINT_OUT_W-1:0] main_joint;
        logic [POS_W-1:0]       main_position;
        logic [PULSE_W-1:0]     main_pulse_ns;
        logic                   main_changed;
        logic                   partner_valid;
        logic [JOINT_OUT_W-1:0] partner_joint;
        logic [POS_W-1:0]       partner_position;
        logic [PULSE_W-1:0]     partner_pulse_ns;
        logic                   partner_changed;
    } result_item_t;

    // 20000 * pos + 1000000, kept to the pulse field width
    function automatic logic [PULSE_W-1:0] pulse_of(input logic [POS_W-1:0] pos);
        logic [PULSE_W-1:0] p;
        p = PULSE_W'(PULSE_STEP_NS) * PULSE_W'(pos) + PULSE_W'(PULSE_BASE_NS);
        return p;
    endfunction

endpackage

[design/sjjc_stream_if.sv]
// valid/ready stream interface with a typed payload
`timescale 1ns / 1ps

interface sjjc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/servo_joint_jog_controller.sv]
// servo joint jog controller top level
// a result passes the decode register and then the result register before it is valid
// throughput: one tick per cycle unless stalled; the joint position registers are read and written in one pass
// a stalled result holds the pipe; a tick is still taken while the decode stage can move
// reset: pipeline empty, positions 50 (joint 1 at 28), invert mask 18, limits 0 and 100
`timescale 1ns / 1ps

module servo_joint_jog_controller #(
    parameter int NUM_JOINTS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sjjc_stream_if.sink                       tick,
    sjjc_stream_if.source                     result,
    input  logic                              cfg_we,
    input  logic [sjjc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sjjc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sjjc_pkg::*;

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam logic [JW-1:0] LAST_JOINT = JW'(NUM_JOINTS - 1);
    localparam logic [JW-1:0] PREV_JOINT = JW'(NUM_JOINTS - 2);

    // {moved, new position}
    function automatic logic [POS_W:0] jog(input logic [POS_W-1:0] p, input dir_t d,
                                           input logic [POS_W-1:0] lo,
                                           input logic [POS_W-1:0] hi);
        logic [POS_W:0] r;
        r = {1'b0, p};
        if (d == DIR_FWD && p < hi)
            r = {1'b1, p + 7'd1};
        else if (d == DIR_BACK && p > lo)
            r = {1'b1, p - 7'd1};
        return r;
    endfunction

    logic [MASK_W-1:0] invert_mask_reg;
    logic [POS_W-1:0]  pos_min_reg;
    logic [POS_W-1:0]  pos_max_reg;
    logic [POS_W-1:0]  pos_reg  [NUM_JOINTS];
    logic [POS_W-1:0]  pos_next [NUM_JOINTS];

    logic              s1_valid_reg;
    logic [JW-1:0]     s1_joint_reg;
    dir_t              s1_dir_reg;
    logic [JW-1:0]     s1_joint_next;
    dir_t              s1_dir_next;

    logic              out_valid_reg;
    result_item_t      out_reg;
    result_item_t      out_next;

    logic              adv;
    logic              take;
    logic              coupled;
    logic [JW-1:0]     other;
    logic [POS_W:0]    main_step;
    logic [POS_W:0]    part_step;
    dir_t              other_dir;

    assign adv        = s1_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !s1_valid_reg || adv;
    assign take       = tick.valid && tick.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // decode: joint = 15 - code, clamped; direction flipped by the mask
    always_comb
    begin
        logic [CODE_W:0] raw;
        logic [4:0]      j5;
        logic            inv;
        dir_t            d;
        raw = {1'b0, ~tick.data.joint_code};
        if (raw >= (CODE_W+1)'(NUM_JOINTS))
            raw = (CODE_W+1)'(NUM_JOINTS - 1);
        s1_joint_next = JW'(raw);
        j5  = 5'(raw);
        inv = (j5 < 5'd5) && invert_mask_reg[j5[2:0]];
        case (tick.data.jog_direction)
            DIR_FWD:  d = inv ? DIR_BACK : DIR_FWD;
            DIR_BACK: d = inv ? DIR_FWD : DIR_BACK;
            default:  d = DIR_STILL;
        endcase
        s1_dir_next = d;
    end

    always_comb
    begin
        logic [POS_W-1:0] p_other;
        coupled = (s1_joint_reg == LAST_JOINT) || (s1_joint_reg == PREV_JOINT);
        other   = (s1_joint_reg == LAST_JOINT) ? PREV_JOINT : LAST_JOINT;
        p_other = (s1_joint_reg == LAST_JOINT) ? pos_reg[NUM_JOINTS-2]
                                               : pos_reg[NUM_JOINTS-1];
        case (s1_dir_reg)
            DIR_FWD:  other_dir = DIR_BACK;
            DIR_BACK: other_dir = DIR_FWD;
            default:  other_dir = DIR_STILL;
        endcase
        main_step = jog(pos_reg[s1_joint_reg], s1_dir_reg, pos_min_reg, pos_max_reg);
        part_step = jog(p_other, other_dir, pos_min_reg, pos_max_reg);

        out_next.main_joint    = JOINT_OUT_W'(s1_joint_reg);
        out_next.main_position = main_step[POS_W-1:0];
        out_next.main_pulse_ns = pulse_of(main_step[POS_W-1:0]);
        out_next.main_changed  = main_step[POS_W];
        out_next.partner_valid = coupled;
        if (coupled)
        begin
            out_next.partner_joint    = JOINT_OUT_W'(other);
            out_next.partner_position = part_step[POS_W-1:0];
            out_next.partner_pulse_ns = pulse_of(part_step[POS_W-1:0]);
            out_next.partner_changed  = part_step[POS_W];
        end
        else
        begin
            out_next.partner_joint    = '0;
            out_next.partner_position = '0;
            out_next.partner_pulse_ns = '0;
            out_next.partner_changed  = 1'b0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_JOINTS; i++)
        begin
            pos_next[i] = pos_reg[i];
            if (adv && s1_joint_reg == JW'(i))
                pos_next[i] = main_step[POS_W-1:0];
            else if (adv && coupled && other == JW'(i))
                pos_next[i] = part_step[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
                pos_reg[i] <= (i == 1) ? POS_RESET_JOINT1 : POS_RESET;
            invert_mask_reg <= INVERT_RESET;
            pos_min_reg     <= POS_MIN_RESET;
            pos_max_reg     <= POS_MAX_RESET;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
                pos_reg[i] <= pos_next[i];
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INVERT_MASK:  invert_mask_reg <= MASK_W'(cfg_data);
                    REG_POSITION_MIN: pos_min_reg     <= cfg_data;
                    REG_POSITION_MAX: pos_max_reg     <= cfg_data;
                    default:          ;
                endcase
            end
            if (tick.ready)
                s1_valid_reg <= tick.valid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_joint_reg <= s1_joint_next;
            s1_dir_reg   <= s1_dir_next;
        end
        if (adv)
            out_reg <= out_next;
    end

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("tick stalled without a full pipe");

    a_main_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.main_pulse_ns == pulse_of(out_reg.main_position)))
        else $error("main pulse does not match main position");

    a_partner_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.partner_valid) |->
            (out_reg.partner_joint != out_reg.main_joint &&
             (out_reg.partner_joint == JOINT_OUT_W'(LAST_JOINT) ||
              out_reg.partner_joint == JOINT_OUT_W'(PREV_JOINT))))
        else $error("partner joint outside the coupled pair");

    a_partner_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.partner_valid) |->
            (out_reg.partner_position == '0 && out_reg.partner_pulse_ns == '0 &&
             !out_reg.partner_changed))
        else $error("partner fields set for an uncoupled joint");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("result lost after decode stage moved");

endmodule

[tb/tb_servo_joint_jog_controller.sv]
// self-checking testbench for the servo joint jog controller
`timescale 1ns / 1ps

module tb_servo_joint_jog_controller;
    import sjjc_pkg::*;

    localparam int NUM_JOINTS  = 5;
    localparam int PIPE_LAT    = 2;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 140;
    localparam int MAX_PRINTS  = 30;

    localparam int MODE_NORMAL  = 0;
    localparam int MODE_NO_IDLE = 1;
    localparam int MODE_HOLDOFF = 2;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [1:0]        dir;
        bit                pinned;
        result_item_t      want;
    } tick_row_t;

    typedef struct {
        logic [MASK_W-1:0] mask;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        int                mode;
    } limit_set_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sjjc_stream_if #(.payload_t(tick_item_t))   tick_ch ();
    sjjc_stream_if #(.payload_t(result_item_t)) result_ch ();

    servo_joint_jog_controller #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // joint state and register copies that track the block
    logic [POS_W-1:0]  joint_pos [NUM_JOINTS];
    logic [MASK_W-1:0] invert_bits;
    logic [POS_W-1:0]  lo_limit;
    logic [POS_W-1:0]  hi_limit;

    result_item_t expected_moves[$];

    int errors;
    int prints;
    int ticks_in;
    int results_out;
    int main_moves;
    int partner_moves;
    int limit_holds;
    int idle_mode;
    bit hold_req;
    int hold_left;
    int stall_count;

    tick_row_t  tick_rows [23];
    limit_set_t limit_sets [7];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic [PULSE_W-1:0] pulse_width(logic [POS_W-1:0] pos);
        return PULSE_W'(PULSE_STEP_NS * int'(pos) + PULSE_BASE_NS);
    endfunction

    function automatic bit step_joint(int idx, dir_t d);
        logic [POS_W-1:0] p;
        p = joint_pos[idx];
        if (d == DIR_FWD && p < hi_limit)
        begin
            joint_pos[idx] = p + 1'b1;
            return 1'b1;
        end
        if (d == DIR_BACK && p > lo_limit)
        begin
            joint_pos[idx] = p - 1'b1;
            return 1'b1;
        end
        if (d != DIR_STILL)
            limit_holds++;
        return 1'b0;
    endfunction

    function automatic result_item_t jog_tick(logic [CODE_W-1:0] code, logic [1:0] dir_raw);
        result_item_t r;
        int           sel;
        int           mate;
        dir_t         d;
        dir_t         mate_dir;
        bit           coupled;
        r = '0;
        sel = 15 - int'(code);
        if (sel >= NUM_JOINTS)
            sel = NUM_JOINTS - 1;
        d = (dir_raw == 2'd3) ? DIR_STILL : dir_t'(dir_raw);
        if (sel < MASK_W && invert_bits[sel])
        begin
            if (d == DIR_FWD)
                d = DIR_BACK;
            else if (d == DIR_BACK)
                d = DIR_FWD;
        end
        coupled = (sel >= NUM_JOINTS - 2);
        r.main_changed = step_joint(sel, d);
        if (coupled)
        begin
            mate = (sel == NUM_JOINTS - 1) ? NUM_JOINTS - 2 : NUM_JOINTS - 1;
            mate_dir = DIR_STILL;
            if (d == DIR_FWD)
                mate_dir = DIR_BACK;
            else if (d == DIR_BACK)
                mate_dir = DIR_FWD;
            r.partner_changed  = step_joint(mate, mate_dir);
            r.partner_valid    = 1'b1;
            r.partner_joint    = JOINT_OUT_W'(mate);
            r.partner_position = joint_pos[mate];
            r.partner_pulse_ns = pulse_width(joint_pos[mate]);
        end
        r.main_joint    = JOINT_OUT_W'(sel);
        r.main_position = joint_pos[sel];
        r.main_pulse_ns = pulse_width(joint_pos[sel]);
        main_moves    += r.main_changed;
        partner_moves += r.partner_changed;
        return r;
    endfunction

    function automatic result_item_t make_result(int mj, int mpos, int mpulse, int mchg,
                                                 int pv, int pj, int ppos, int ppulse,
                                                 int pchg);
        result_item_t r;
        r.main_joint       = JOINT_OUT_W'(mj);
        r.main_position    = POS_W'(mpos);
        r.main_pulse_ns    = PULSE_W'(mpulse);
        r.main_changed     = 1'(mchg);
        r.partner_valid    = 1'(pv);
        r.partner_joint    = JOINT_OUT_W'(pj);
        r.partner_position = POS_W'(ppos);
        r.partner_pulse_ns = PULSE_W'(ppulse);
        r.partner_changed  = 1'(pchg);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        if (prints < MAX_PRINTS)
        begin
            prints++;
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    task automatic check_result(result_item_t got, result_item_t want);
        if (got.main_joint != want.main_joint)
            report_mismatch("main_joint", got.main_joint, want.main_joint);
        if (got.main_position != want.main_position)
            report_mismatch("main_position", got.main_position, want.main_position);
        if (got.main_pulse_ns != want.main_pulse_ns)
            report_mismatch("main_pulse_ns", got.main_pulse_ns, want.main_pulse_ns);
        if (got.main_changed != want.main_changed)
            report_mismatch("main_changed", got.main_changed, want.main_changed);
        if (got.partner_valid != want.partner_valid)
            report_mismatch("partner_valid", got.partner_valid, want.partner_valid);
        if (got.partner_joint != want.partner_joint)
            report_mismatch("partner_joint", got.partner_joint, want.partner_joint);
        if (got.partner_position != want.partner_position)
            report_mismatch("partner_position", got.partner_position, want.partner_position);
        if (got.partner_pulse_ns != want.partner_pulse_ns)
            report_mismatch("partner_pulse_ns", got.partner_pulse_ns, want.partner_pulse_ns);
        if (got.partner_changed != want.partner_changed)
            report_mismatch("partner_changed", got.partner_changed, want.partner_changed);
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_tick(logic [CODE_W-1:0] code, logic [1:0] dir, bit pinned,
                             result_item_t want);
        result_item_t predicted;
        if (idle_mode == MODE_NORMAL)
        begin
            while ($urandom_range(99) < 26)
            begin
                tick_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.data.joint_code <= code;
        tick_ch.data.jog_direction <= dir;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        predicted = jog_tick(code, dir);
        expected_moves.push_back(pinned ? want : predicted);
        ticks_in++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        while (expected_moves.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT) @(negedge clk);
    endtask

    task automatic apply_limits(limit_set_t s);
        cfg_we    <= 1'b1;
        cfg_index <= REG_INVERT_MASK;
        cfg_data  <= CFG_DATA_W'(s.mask);
        invert_bits = s.mask;
        @(negedge clk);
        cfg_index <= REG_POSITION_MIN;
        cfg_data  <= s.lo;
        lo_limit = s.lo;
        @(negedge clk);
        cfg_index <= REG_POSITION_MAX;
        cfg_data  <= s.hi;
        hi_limit = s.hi;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver side: random back-pressure, plus one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (idle_mode == MODE_NO_IDLE)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= 26);
        end
    end

    // result checking and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_count++;
            if (tick_ch.valid && tick_ch.ready)
                stall_count = 0;
            if (result_ch.valid && result_ch.ready)
            begin
                stall_count = 0;
                results_out++;
                if (expected_moves.size() == 0)
                    report_mismatch("result transfer with nothing expected", 1, 0);
                else
                    check_result(result_ch.data, expected_moves.pop_front());
            end
            if (stall_count >= STALL_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, expected_moves.size());
                $display("tb_servo_joint_jog_controller: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int               burst;
        int               pick;
        int               sent;
        logic [CODE_W-1:0] code;
        logic [1:0]        dir;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        hold_req      = 1'b0;
        idle_mode     = MODE_NORMAL;
        errors        = 0;
        prints        = 0;
        ticks_in      = 0;
        results_out   = 0;
        main_moves    = 0;
        partner_moves = 0;
        limit_holds   = 0;
        stall_count   = 0;

        for (int i = 0; i < NUM_JOINTS; i++)
            joint_pos[i] = POS_RESET;
        joint_pos[1] = POS_RESET_JOINT1;
        invert_bits = INVERT_RESET;
        lo_limit    = POS_MIN_RESET;
        hi_limit    = POS_MAX_RESET;

        // reset state read straight off: first joint, offset joint 1, direction three,
        // both coupled joints, and a code clamped to the last joint
        tick_rows = '{
            '{4'd15, 2'd0, 1'b1, make_result(0, 50, 2000000, 0, 0, 0, 0, 0, 0)},
            '{4'd14, 2'd0, 1'b1, make_result(1, 28, 1560000, 0, 0, 0, 0, 0, 0)},
            '{4'd13, 2'd3, 1'b1, make_result(2, 50, 2000000, 0, 0, 0, 0, 0, 0)},
            '{4'd12, 2'd0, 1'b1, make_result(3, 50, 2000000, 0, 1, 4, 50, 2000000, 0)},
            '{4'd0,  2'd3, 1'b1, make_result(4, 50, 2000000, 0, 1, 3, 50, 2000000, 0)},
            '{4'd15, 2'd1, 1'b0, '0},
            '{4'd15, 2'd2, 1'b0, '0},
            '{4'd14, 2'd1, 1'b0, '0},
            '{4'd14, 2'd2, 1'b0, '0},
            '{4'd14, 2'd2, 1'b0, '0},
            '{4'd13, 2'd1, 1'b0, '0},
            '{4'd13, 2'd2, 1'b0, '0},
            '{4'd12, 2'd1, 1'b0, '0},
            '{4'd12, 2'd2, 1'b0, '0},
            '{4'd11, 2'd1, 1'b0, '0},
            '{4'd11, 2'd2, 1'b0, '0},
            '{4'd5,  2'd1, 1'b0, '0},
            '{4'd1,  2'd2, 1'b0, '0},
            '{4'd12, 2'd3, 1'b0, '0},
            '{4'd10, 2'd0, 1'b0, '0},
            '{4'd3,  2'd1, 1'b0, '0},
            '{4'd7,  2'd2, 1'b0, '0},
            '{4'd15, 2'd3, 1'b0, '0}
        };

        // register settings: all-clear and all-set masks, narrow window, both limits at
        // the top, both at zero, min above max, and the reset mask in a second narrow window
        limit_sets = '{
            '{5'd0,  7'd0,   7'd100, MODE_NORMAL},
            '{5'd31, 7'd0,   7'd100, MODE_HOLDOFF},
            '{5'd10, 7'd40,  7'd60,  MODE_NORMAL},
            '{5'd31, 7'd100, 7'd100, MODE_NO_IDLE},
            '{5'd0,  7'd0,   7'd0,   MODE_NORMAL},
            '{5'd21, 7'd80,  7'd20,  MODE_NORMAL},
            '{5'd18, 7'd45,  7'd55,  MODE_NORMAL}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (tick_rows[i])
            send_tick(tick_rows[i].code, tick_rows[i].dir, tick_rows[i].pinned,
                      tick_rows[i].want);

        foreach (limit_sets[p])
        begin
            drain_results();
            idle_mode = MODE_NORMAL;
            apply_limits(limit_sets[p]);
            idle_mode = limit_sets[p].mode;
            if (idle_mode == MODE_HOLDOFF)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // long same-direction runs drive joints into their limits
                burst = $urandom_range(1, 40);
                if ($urandom_range(1))
                    code = CODE_W'($urandom_range(15));
                else
                    code = CODE_W'($urandom_range(12, 15));
                pick = $urandom_range(9);
                dir = (pick < 4) ? 2'd1 : (pick < 8) ? 2'd2 : (pick == 8) ? 2'd0 : 2'd3;
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++)
                begin
                    if ($urandom_range(9) == 0)
                        send_tick(CODE_W'($urandom_range(15)), 2'($urandom_range(3)),
                                  1'b0, '0);
                    else
                        send_tick(code, dir, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_results();
        repeat (PIPE_LAT + 4) @(negedge clk);

        $display("run covered %0d ticks and %0d results over %0d register settings",
                 ticks_in, results_out, $size(limit_sets) + 1);
        $display("joint steps %0d, coupled partner steps %0d, jogs held at a limit %0d",
                 main_moves, partner_moves, limit_holds);
        if (errors == 0 && expected_moves.size() == 0)
            $display("tb_servo_joint_jog_controller: clean");
        else
            $display("tb_servo_joint_jog_controller: errors");
        $finish;
    end

endmodule
